@@ rtl/utu_pkg.sv @@
// Shared types, constants and lead-byte helpers for the UTF-8 to UTF-16 transcoder.
package utu_pkg;

   typedef logic [15:0] unit_type;
   typedef logic [2:0]  seq_len_type;

   typedef struct packed {
      logic [1:0]     count;
      unit_type [2:0] unit;
   } unit_list_type;

   localparam unit_type    REPL_CHAR  = 16'hFFFD;
   localparam unit_type    SUR_HIGH   = 16'hD800;
   localparam unit_type    SUR_LOW    = 16'hDC00;
   localparam logic [20:0] SUPP_BASE  = 21'h010000;
   localparam logic [20:0] BMP_TOP    = 21'h00FFFF;

   localparam seq_len_type LEN_BAD    = 3'd0;
   localparam seq_len_type LEN_ONE    = 3'd1;
   localparam seq_len_type LEN_TWO    = 3'd2;
   localparam seq_len_type LEN_THREE  = 3'd3;
   localparam seq_len_type LEN_FOUR   = 3'd4;

   function automatic seq_len_type lead_length(input logic [7:0] c);
      seq_len_type len;
      if (c[7] == 1'b0) begin
         len = LEN_ONE;
      end else if (c[7:5] == 3'b110) begin
         len = LEN_TWO;
      end else if (c[7:4] == 4'b1110) begin
         len = LEN_THREE;
      end else if (c[7:3] == 5'b11110) begin
         len = LEN_FOUR;
      end else begin
         len = LEN_BAD;
      end
      return len;
   endfunction

   // Decode one byte as a closed string of its own.
   function automatic unit_type single_unit(input logic [7:0] c);
      return (c[7] == 1'b0) ? {8'h00, c} : REPL_CHAR;
   endfunction

endpackage

@@ rtl/utf8_to_utf16_transcoder.sv @@
// Top level: lenient UTF-8 byte stream to UTF-16 code unit converter.
//
//  channel | ports                                  | carries
//  --------+----------------------------------------+-------------------------------
//  req     | req_valid req_stall req_byte_in        | one UTF-8 byte, last-byte flag
//          | req_final_byte                         |
//  rsp     | rsp_valid rsp_stall rsp_code_unit      | one UTF-16 code unit, end flag
//          | rsp_end_of_string                      |
//
//  One byte per cycle while req_stall is low: input register, one decode pass, three-entry result buffer.
//  A byte giving 2 or 3 code units holds the next byte until only its last unit is left.
//  The input register feeds the decode pass, whose units are registered in the result buffer.
//  Synchronous active-high reset empties both stages and the held sequence.
//  rsp_stall holds the result buffer; req_stall rises only while it cannot take
//  the decoded units of the registered byte.
module utf8_to_utf16_transcoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_byte_in,
   input  logic                req_final_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output utu_pkg::unit_type   rsp_code_unit,
   output logic                rsp_end_of_string
);
   import utu_pkg::*;

   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    s1_byte_ff;
   logic          s1_final_ff;

   logic [7:0]    held_ff [3];
   logic [1:0]    held_cnt_ff, held_cnt_in;
   seq_len_type   seq_len_ff, seq_len_in;
   logic [2:0]    held_wr;

   unit_type      buf_unit_ff [3];
   unit_type      buf_unit_in [3];
   logic [1:0]    buf_cnt_ff, buf_cnt_in;
   logic          eos_ff, eos_in;

   unit_list_type dec_list;
   logic          load_ok, s1_adv, req_xfer, rsp_xfer;

   assign rsp_valid         = (buf_cnt_ff != 2'd0);
   assign rsp_code_unit     = buf_unit_ff[0];
   assign rsp_end_of_string = eos_ff && (buf_cnt_ff == 2'd1);
   assign rsp_xfer          = rsp_valid && !rsp_stall;
   assign load_ok           = (buf_cnt_ff == 2'd0) || ((buf_cnt_ff == 2'd1) && !rsp_stall);
   assign s1_adv            = s1_valid_ff && load_ok;
   assign req_stall         = s1_valid_ff && !load_ok;
   assign req_xfer          = req_valid && !req_stall;

   // decode the registered byte against the held sequence
   always_comb begin
      logic [7:0]    d0, d1, d2;
      logic [20:0]   cp, v;
      logic          complete;
      unit_list_type full_list;

      d0 = (held_cnt_ff == 2'd0) ? s1_byte_ff : held_ff[0];
      d1 = (held_cnt_ff == 2'd1) ? s1_byte_ff : held_ff[1];
      d2 = (held_cnt_ff == 2'd2) ? s1_byte_ff : held_ff[2];

      case (seq_len_ff)
         LEN_TWO:   cp = {10'b0, d0[4:0], d1[5:0]};
         LEN_THREE: cp = {5'b0, d0[3:0], d1[5:0], d2[5:0]};
         default:   cp = {d0[2:0], d1[5:0], d2[5:0], s1_byte_ff[5:0]};
      endcase
      v = cp - SUPP_BASE;

      full_list = '0;
      if (cp > BMP_TOP) begin
         full_list.count   = 2'd2;
         full_list.unit[0] = SUR_HIGH | {6'b0, v[19:10]};
         full_list.unit[1] = SUR_LOW | {6'b0, v[9:0]};
      end else begin
         full_list.count   = 2'd1;
         full_list.unit[0] = cp[15:0];
      end

      complete = ({1'b0, held_cnt_ff} + 3'd1) >= seq_len_ff;

      dec_list    = '0;
      held_wr     = 3'b000;
      held_cnt_in = held_cnt_ff;
      seq_len_in  = seq_len_ff;

      if (held_cnt_ff == 2'd0) begin
         if (s1_final_ff) begin
            dec_list.count   = 2'd1;
            dec_list.unit[0] = single_unit(s1_byte_ff);
         end else begin
            case (lead_length(s1_byte_ff))
               LEN_ONE: begin
                  dec_list.count   = 2'd1;
                  dec_list.unit[0] = {8'h00, s1_byte_ff};
               end
               LEN_BAD: begin
                  dec_list.count   = 2'd1;
                  dec_list.unit[0] = REPL_CHAR;
               end
               default: begin
                  held_wr     = 3'b001;
                  held_cnt_in = 2'd1;
                  seq_len_in  = lead_length(s1_byte_ff);
               end
            endcase
         end
      end else if (complete) begin
         dec_list    = full_list;
         held_cnt_in = 2'd0;
         seq_len_in  = LEN_BAD;
      end else if (s1_final_ff) begin
         // cut-off lead: replace it, then decode the rest on its own
         dec_list.unit[0] = REPL_CHAR;
         held_cnt_in      = 2'd0;
         seq_len_in       = LEN_BAD;
         if (held_cnt_ff == 2'd1) begin
            dec_list.count   = 2'd2;
            dec_list.unit[1] = single_unit(s1_byte_ff);
         end else begin
            case (lead_length(held_ff[1]))
               LEN_ONE: begin
                  dec_list.count   = 2'd3;
                  dec_list.unit[1] = {8'h00, held_ff[1]};
                  dec_list.unit[2] = single_unit(s1_byte_ff);
               end
               LEN_TWO: begin
                  dec_list.count   = 2'd2;
                  dec_list.unit[1] = {5'b0, held_ff[1][4:0], s1_byte_ff[5:0]};
               end
               default: begin
                  dec_list.count   = 2'd3;
                  dec_list.unit[1] = REPL_CHAR;
                  dec_list.unit[2] = single_unit(s1_byte_ff);
               end
            endcase
         end
      end else begin
         held_wr     = 3'(3'b001 << held_cnt_ff);
         held_cnt_in = 2'(held_cnt_ff + 2'd1);
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // load the buffer on advance, else shift one unit out per transfer
   always_comb begin
      buf_unit_in = buf_unit_ff;
      buf_cnt_in  = buf_cnt_ff;
      eos_in      = eos_ff;
      if (s1_adv) begin
         buf_unit_in[0] = dec_list.unit[0];
         buf_unit_in[1] = dec_list.unit[1];
         buf_unit_in[2] = dec_list.unit[2];
         buf_cnt_in     = dec_list.count;
         eos_in         = s1_final_ff;
      end else if (rsp_xfer) begin
         buf_unit_in[0] = buf_unit_ff[1];
         buf_unit_in[1] = buf_unit_ff[2];
         buf_cnt_in     = 2'(buf_cnt_ff - 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         held_cnt_ff <= 2'd0;
         seq_len_ff  <= LEN_BAD;
         buf_cnt_ff  <= 2'd0;
         eos_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         buf_cnt_ff  <= buf_cnt_in;
         eos_ff      <= eos_in;
         if (s1_adv) begin
            held_cnt_ff <= held_cnt_in;
            seq_len_ff  <= seq_len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_byte_ff  <= req_byte_in;
         s1_final_ff <= req_final_byte;
      end
      buf_unit_ff <= buf_unit_in;
      for (int i = 0; i < 3; i++) begin
         if (s1_adv && held_wr[i]) begin
            held_ff[i] <= s1_byte_ff;
         end
      end
   end

`ifndef SYNTH
   a_held_below_len: assert property (@(posedge clock) disable iff (reset)
      (held_cnt_ff != 2'd0) |-> ({1'b0, held_cnt_ff} < seq_len_ff))
      else $error("held byte count reached the sequence length");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_final_ff) |=> (held_cnt_ff == 2'd0) && rsp_valid && eos_ff)
      else $error("final byte did not close the string");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid)
      else $error("input stalled with nothing pending");

   a_hold_no_units: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && !s1_final_ff && (held_cnt_in != 2'd0)) |=> !rsp_valid)
      else $error("held byte produced a code unit");
`endif

endmodule
